// ===== rtl/mbet_pkg.sv =====
// ----------------------------------------------------------------------------
// mbet_pkg
// types, codes and fixed constants shared by the escape-time pixel engine
// ----------------------------------------------------------------------------
`default_nettype none

package mbet_pkg;

    localparam int COORD_W     = 10;
    localparam int COORD_CMP_W = 13;
    localparam int COUNT_W     = 16;
    localparam int COLOR_W     = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int FX_W        = 64;
    localparam int HALF_W      = 32;
    localparam int STEP_W      = 31;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_X_ORIGIN       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_Y_ORIGIN       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_X_STEP         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_Y_STEP         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ITER_LIMIT     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PALETTE_RED    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_PALETTE_GREEN  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_PALETTE_BLUE   = 3'd7;

    // register reset values
    localparam logic [31:0]        RST_X_ORIGIN      = 32'hE000_0000;
    localparam logic [31:0]        RST_Y_ORIGIN      = 32'd322122547;
    localparam logic [STEP_W-1:0]  RST_X_STEP        = 31'd1258291;
    localparam logic [STEP_W-1:0]  RST_Y_STEP        = 31'd1342177;
    localparam logic [COUNT_W-1:0] RST_ITER_LIMIT    = 16'd255;
    localparam logic [COLOR_W-1:0] RST_PALETTE_RED   = 8'd10;
    localparam logic [COLOR_W-1:0] RST_PALETTE_GREEN = 8'd5;
    localparam logic [COLOR_W-1:0] RST_PALETTE_BLUE  = 8'd1;

    // shade is count + 50 + 1, only its low byte matters for the colors
    localparam logic [COLOR_W-1:0] SHADE_OFFSET = 8'd51;

    localparam logic [FX_W-1:0] FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
    localparam logic [FX_W-1:0] FX_MIN = {1'b1, {(FX_W-1){1'b0}}};

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
    } pixel_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_column;
        logic [COORD_W-1:0] pixel_row;
        logic [COUNT_W-1:0] iterations;
        logic               escaped;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_C_MUL_X,
        ST_C_ADD_X,
        ST_C_MUL_Y,
        ST_C_ADD_Y,
        ST_CHECK,
        ST_MUL,
        ST_MUL_FIN,
        ST_ADD,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MUL_ZR_ZI,
        MUL_ZR_ZR,
        MUL_ZI_ZI
    } mul_sel_t;

endpackage

`default_nettype wire

// ===== rtl/mbet_stream_if.sv =====
// ----------------------------------------------------------------------------
// mbet_stream_if
// valid/ready channel carrying one payload struct per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface mbet_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/mandelbrot_escape_time_pixel_top.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_top
// escape-time engine: one pixel coordinate in, one count and color out
// ----------------------------------------------------------------------------
// usage
//   pixel  : sink channel, one transaction per pixel (column, row)
//   result : source channel, one transaction per pixel with the echoed
//            coordinate, iteration count, escaped flag and rgb bytes
//   cfg_*  : write-only register port, write only while the engine is idle
// timing
//   a single 32x32 multiplier and a single saturating 64-bit adder form the
//   partial products and the sums of c and of the orbit under a small
//   sequencer; each 64x64 fixed-point product runs through operand load,
//   four partial products, final accumulate, and truncate and saturate, and
//   one orbit step is the zr*zi product, four additions, the two squares
//   and the escape check; no new pixel is taken while one is in flight
//   pixel.ready is high only while the sequencer is idle
// reset
//   rst_n clears the sequencer and the output valid and reloads the default
//   view and palette registers
// stall
//   the result sits in an output register; a finished pixel waits in the
//   done state while that register is still full, and the engine takes the
//   next pixel once the result has moved into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time_pixel_top #(
    parameter int FRAC_BITS    = 28,
    parameter int ESCAPE_BOUND = 4,
    parameter int COLUMN_LIMIT = 1024,
    parameter int ROW_LIMIT    = 1024
) (
    input  wire                                clk,
    input  wire                                rst_n,
    mbet_stream_if.sink                        pixel,
    mbet_stream_if.source                      result,
    input  wire                                cfg_write,
    input  wire  [mbet_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire  [mbet_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int FxW = mbet_pkg::FX_W;
    localparam int HW  = mbet_pkg::HALF_W;
    localparam int CW  = mbet_pkg::COUNT_W;

    // escape bound in fixed point
    localparam logic [FxW-1:0] BoundFx = FxW'(ESCAPE_BOUND) << FRAC_BITS;

    // ---------------------------------------------------------------- config
    logic [31:0]                       x_origin_reg;
    logic [31:0]                       y_origin_reg;
    logic [mbet_pkg::STEP_W-1:0]       x_step_reg;
    logic [mbet_pkg::STEP_W-1:0]       y_step_reg;
    logic [CW-1:0]                     iter_limit_reg;
    logic [mbet_pkg::COLOR_W-1:0]      pal_red_reg;
    logic [mbet_pkg::COLOR_W-1:0]      pal_green_reg;
    logic [mbet_pkg::COLOR_W-1:0]      pal_blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg   <= mbet_pkg::RST_X_ORIGIN;
            y_origin_reg   <= mbet_pkg::RST_Y_ORIGIN;
            x_step_reg     <= mbet_pkg::RST_X_STEP;
            y_step_reg     <= mbet_pkg::RST_Y_STEP;
            iter_limit_reg <= mbet_pkg::RST_ITER_LIMIT;
            pal_red_reg    <= mbet_pkg::RST_PALETTE_RED;
            pal_green_reg  <= mbet_pkg::RST_PALETTE_GREEN;
            pal_blue_reg   <= mbet_pkg::RST_PALETTE_BLUE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mbet_pkg::CFG_X_ORIGIN:      x_origin_reg   <= cfg_data;
                mbet_pkg::CFG_Y_ORIGIN:      y_origin_reg   <= cfg_data;
                mbet_pkg::CFG_X_STEP:        x_step_reg     <= cfg_data[30:0];
                mbet_pkg::CFG_Y_STEP:        y_step_reg     <= cfg_data[30:0];
                mbet_pkg::CFG_ITER_LIMIT:    iter_limit_reg <= cfg_data[15:0];
                mbet_pkg::CFG_PALETTE_RED:   pal_red_reg    <= cfg_data[7:0];
                mbet_pkg::CFG_PALETTE_GREEN: pal_green_reg  <= cfg_data[7:0];
                mbet_pkg::CFG_PALETTE_BLUE:  pal_blue_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------- registers
    mbet_pkg::state_t   state_reg, state_next;
    mbet_pkg::mul_sel_t mul_sel_reg, mul_sel_next;
    logic [2:0]         step_reg, step_next;
    logic               out_valid_reg, out_valid_next;
    mbet_pkg::result_t  out_reg, out_next;

    // orbit and point in signed fixed point, then count, limit and coordinates
    logic [FxW-1:0]     zr_reg, zr_next;
    logic [FxW-1:0]     zi_reg, zi_next;
    logic [FxW-1:0]     tr_reg, tr_next;
    logic [FxW-1:0]     ti_reg, ti_next;
    logic [FxW-1:0]     cr_reg, cr_next;
    logic [FxW-1:0]     ci_reg, ci_next;
    logic [FxW-1:0]     p_reg, p_next;
    logic [FxW-1:0]     tmp_reg, tmp_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      limit_reg, limit_next;
    logic [mbet_pkg::COORD_W-1:0] col_reg, col_next;
    logic [mbet_pkg::COORD_W-1:0] row_reg, row_next;

    // multiplier datapath
    logic [FxW-1:0]     mag_a_reg, mag_a_next;
    logic [FxW-1:0]     mag_b_reg, mag_b_next;
    logic               neg_reg, neg_next;
    logic [2*HW-1:0]    prod_reg, prod_next;
    logic [2*FxW-1:0]   acc_reg, acc_next;

    // ---------------------------------------------------------- shared units
    logic [HW-1:0]      mul_a, mul_b;
    logic [2*HW-1:0]    mul_p;
    logic [FxW-1:0]     add_a, add_b, add_y;
    logic               add_sub;
    logic [FxW:0]       add_b_ext, add_sum;

    assign mul_p = (2*HW)'(mul_a) * (2*HW)'(mul_b);

    // saturating add/subtract on 64-bit signed values
    always_comb
    begin
        add_b_ext = {add_b[FxW-1], add_b};
        if (add_sub)
        begin
            add_b_ext = ~add_b_ext + 1'b1;
        end
        add_sum = {add_a[FxW-1], add_a} + add_b_ext;
        if (add_sum[FxW] != add_sum[FxW-1])
        begin
            add_y = add_sum[FxW] ? mbet_pkg::FX_MIN : mbet_pkg::FX_MAX;
        end
        else
        begin
            add_y = add_sum[FxW-1:0];
        end
    end

    // clamped coordinates for forming c
    logic [mbet_pkg::COORD_W-1:0] col_c, row_c;

    assign col_c = ({3'b0, col_reg} >= mbet_pkg::COORD_CMP_W'(COLUMN_LIMIT))
                 ? mbet_pkg::COORD_W'(COLUMN_LIMIT - 1) : col_reg;
    assign row_c = ({3'b0, row_reg} >= mbet_pkg::COORD_CMP_W'(ROW_LIMIT))
                 ? mbet_pkg::COORD_W'(ROW_LIMIT - 1) : row_reg;

    // magnitude and sign of the product operands
    logic [FxW-1:0] src_a, src_b, abs_a, abs_b;

    always_comb
    begin
        case (mul_sel_reg)
            mbet_pkg::MUL_ZR_ZI:
            begin
                src_a = zr_reg;
                src_b = zi_reg;
            end
            mbet_pkg::MUL_ZR_ZR:
            begin
                src_a = zr_reg;
                src_b = zr_reg;
            end
            mbet_pkg::MUL_ZI_ZI:
            begin
                src_a = zi_reg;
                src_b = zi_reg;
            end
            default:
            begin
                src_a = zr_reg;
                src_b = zi_reg;
            end
        endcase
        abs_a = src_a[FxW-1] ? (~src_a + 1'b1) : src_a;
        abs_b = src_b[FxW-1] ? (~src_b + 1'b1) : src_b;
    end

    // truncate toward zero by FRAC_BITS, saturate, restore sign
    logic [2*FxW-1:0] fin_shift;
    logic [FxW-1:0]   fin_limit, fin_mag, fin_res;

    always_comb
    begin
        fin_shift = acc_reg >> FRAC_BITS;
        fin_limit = neg_reg ? mbet_pkg::FX_MIN : mbet_pkg::FX_MAX;
        if ((|fin_shift[2*FxW-1:FxW]) || (fin_shift[FxW-1:0] > fin_limit))
        begin
            fin_mag = fin_limit;
        end
        else
        begin
            fin_mag = fin_shift[FxW-1:0];
        end
        fin_res = neg_reg ? (~fin_mag + 1'b1) : fin_mag;
    end

    // orbit continues while below the limit and inside the bound
    logic run_on;

    assign run_on = (count_reg < limit_reg) && (add_y <= BoundFx);

    // colors from the low byte of the shade, products kept modulo 256
    logic                          done_free;
    logic                          esc;
    logic [mbet_pkg::COLOR_W-1:0]  shade;
    logic [mbet_pkg::COLOR_W-1:0]  prod_red, prod_green, prod_blue;

    assign done_free  = !out_valid_reg || result.ready;
    assign esc        = (count_reg != limit_reg);
    assign shade      = count_reg[mbet_pkg::COLOR_W-1:0] + mbet_pkg::SHADE_OFFSET;
    assign prod_red   = pal_red_reg * shade;
    assign prod_green = pal_green_reg * shade;
    assign prod_blue  = pal_blue_reg * shade;

    // ---------------------------------------------------- next state / control
    always_comb
    begin
        state_next   = state_reg;
        mul_sel_next = mul_sel_reg;
        step_next    = step_reg;
        case (state_reg)
            mbet_pkg::ST_IDLE:
            begin
                if (pixel.valid)
                begin
                    state_next = mbet_pkg::ST_C_MUL_X;
                end
            end
            mbet_pkg::ST_C_MUL_X: state_next = mbet_pkg::ST_C_ADD_X;
            mbet_pkg::ST_C_ADD_X: state_next = mbet_pkg::ST_C_MUL_Y;
            mbet_pkg::ST_C_MUL_Y: state_next = mbet_pkg::ST_C_ADD_Y;
            mbet_pkg::ST_C_ADD_Y: state_next = mbet_pkg::ST_CHECK;
            mbet_pkg::ST_CHECK:
            begin
                if (run_on)
                begin
                    state_next   = mbet_pkg::ST_MUL;
                    mul_sel_next = mbet_pkg::MUL_ZR_ZI;
                    step_next    = 3'd0;
                end
                else
                begin
                    state_next = mbet_pkg::ST_DONE;
                end
            end
            mbet_pkg::ST_MUL:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd5)
                begin
                    state_next = mbet_pkg::ST_MUL_FIN;
                end
            end
            mbet_pkg::ST_MUL_FIN:
            begin
                step_next = 3'd0;
                case (mul_sel_reg)
                    mbet_pkg::MUL_ZR_ZI: state_next = mbet_pkg::ST_ADD;
                    mbet_pkg::MUL_ZR_ZR:
                    begin
                        state_next   = mbet_pkg::ST_MUL;
                        mul_sel_next = mbet_pkg::MUL_ZI_ZI;
                    end
                    default:             state_next = mbet_pkg::ST_CHECK;
                endcase
            end
            mbet_pkg::ST_ADD:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd3)
                begin
                    state_next   = mbet_pkg::ST_MUL;
                    mul_sel_next = mbet_pkg::MUL_ZR_ZR;
                    step_next    = 3'd0;
                end
            end
            mbet_pkg::ST_DONE:
            begin
                if (done_free)
                begin
                    state_next = mbet_pkg::ST_IDLE;
                end
            end
            default: state_next = mbet_pkg::ST_IDLE;
        endcase
    end

    // -------------------------------------------------------- datapath / outputs
    always_comb
    begin
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        tr_next    = tr_reg;
        ti_next    = ti_reg;
        cr_next    = cr_reg;
        ci_next    = ci_reg;
        p_next     = p_reg;
        tmp_next   = tmp_reg;
        count_next = count_reg;
        limit_next = limit_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        mag_a_next = mag_a_reg;
        mag_b_next = mag_b_reg;
        neg_next   = neg_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        out_next   = out_reg;
        mul_a      = '0;
        mul_b      = '0;
        add_a      = tr_reg;
        add_b      = ti_reg;
        add_sub    = 1'b0;

        out_valid_next = out_valid_reg && !result.ready;

        case (state_reg)
            mbet_pkg::ST_IDLE:
            begin
                if (pixel.valid)
                begin
                    col_next   = pixel.payload.column;
                    row_next   = pixel.payload.row;
                    limit_next = iter_limit_reg;
                    count_next = '0;
                    zr_next    = '0;
                    zi_next    = '0;
                    tr_next    = '0;
                    ti_next    = '0;
                end
            end
            mbet_pkg::ST_C_MUL_X:
            begin
                mul_a     = HW'(col_c);
                mul_b     = HW'(x_step_reg);
                prod_next = mul_p;
            end
            mbet_pkg::ST_C_ADD_X:
            begin
                add_a   = {{(FxW-32){x_origin_reg[31]}}, x_origin_reg};
                add_b   = prod_reg;
                cr_next = add_y;
            end
            mbet_pkg::ST_C_MUL_Y:
            begin
                mul_a     = HW'(row_c);
                mul_b     = HW'(y_step_reg);
                prod_next = mul_p;
            end
            mbet_pkg::ST_C_ADD_Y:
            begin
                add_a   = {{(FxW-32){y_origin_reg[31]}}, y_origin_reg};
                add_b   = prod_reg;
                add_sub = 1'b1;
                ci_next = add_y;
            end
            mbet_pkg::ST_CHECK:
            begin
                // |z|^2 = tr + ti, tested in run_on
                add_a = tr_reg;
                add_b = ti_reg;
            end
            mbet_pkg::ST_MUL:
            begin
                // step 0 loads operands, 1..4 multiply halves, 2..5 accumulate
                case (step_reg)
                    3'd0:
                    begin
                        mag_a_next = abs_a;
                        mag_b_next = abs_b;
                        neg_next   = src_a[FxW-1] ^ src_b[FxW-1];
                        acc_next   = '0;
                    end
                    3'd1:
                    begin
                        mul_a     = mag_a_reg[HW-1:0];
                        mul_b     = mag_b_reg[HW-1:0];
                        prod_next = mul_p;
                    end
                    3'd2:
                    begin
                        mul_a     = mag_a_reg[HW-1:0];
                        mul_b     = mag_b_reg[FxW-1:HW];
                        prod_next = mul_p;
                        acc_next  = acc_reg + (2*FxW)'(prod_reg);
                    end
                    3'd3:
                    begin
                        mul_a     = mag_a_reg[FxW-1:HW];
                        mul_b     = mag_b_reg[HW-1:0];
                        prod_next = mul_p;
                        acc_next  = acc_reg + ((2*FxW)'(prod_reg) << HW);
                    end
                    3'd4:
                    begin
                        mul_a     = mag_a_reg[FxW-1:HW];
                        mul_b     = mag_b_reg[FxW-1:HW];
                        prod_next = mul_p;
                        acc_next  = acc_reg + ((2*FxW)'(prod_reg) << HW);
                    end
                    3'd5:
                    begin
                        acc_next = acc_reg + ((2*FxW)'(prod_reg) << (2*HW));
                    end
                    default: ;
                endcase
            end
            mbet_pkg::ST_MUL_FIN:
            begin
                case (mul_sel_reg)
                    mbet_pkg::MUL_ZR_ZI: p_next  = fin_res;
                    mbet_pkg::MUL_ZR_ZR: tr_next = fin_res;
                    default:             ti_next = fin_res;
                endcase
            end
            mbet_pkg::ST_ADD:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        add_a    = p_reg;
                        add_b    = p_reg;
                        tmp_next = add_y;
                    end
                    3'd1:
                    begin
                        add_a   = tmp_reg;
                        add_b   = ci_reg;
                        zi_next = add_y;
                    end
                    3'd2:
                    begin
                        add_a    = tr_reg;
                        add_b    = ti_reg;
                        add_sub  = 1'b1;
                        tmp_next = add_y;
                    end
                    default:
                    begin
                        add_a      = tmp_reg;
                        add_b      = cr_reg;
                        zr_next    = add_y;
                        count_next = count_reg + 1'b1;
                    end
                endcase
            end
            mbet_pkg::ST_DONE:
            begin
                if (done_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.pixel_column = col_reg;
                    out_next.pixel_row    = row_reg;
                    out_next.iterations   = count_reg;
                    out_next.escaped      = esc;
                    out_next.red   = esc ? prod_red[mbet_pkg::COLOR_W-1:0]   : '0;
                    out_next.green = esc ? prod_green[mbet_pkg::COLOR_W-1:0] : '0;
                    out_next.blue  = esc ? prod_blue[mbet_pkg::COLOR_W-1:0]  : '0;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------ flip-flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mbet_pkg::ST_IDLE;
            mul_sel_reg   <= mbet_pkg::MUL_ZR_ZI;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mul_sel_reg   <= mul_sel_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zr_reg    <= zr_next;
        zi_reg    <= zi_next;
        tr_reg    <= tr_next;
        ti_reg    <= ti_next;
        cr_reg    <= cr_next;
        ci_reg    <= ci_next;
        p_reg     <= p_next;
        tmp_reg   <= tmp_next;
        count_reg <= count_next;
        limit_reg <= limit_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
        mag_a_reg <= mag_a_next;
        mag_b_reg <= mag_b_next;
        neg_reg   <= neg_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        out_reg   <= out_next;
    end

    // ---------------------------------------------------------------- ports
    assign pixel.ready    = (state_reg == mbet_pkg::ST_IDLE);
    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    // ----------------------------------------------------------- assertions
`ifndef ASSERT_OFF
    // a pixel transaction starts the point computation
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        pixel.valid && pixel.ready |=> state_reg == mbet_pkg::ST_C_MUL_X)
        else $error("pixel transaction did not start the sequencer");

    // the iteration count never passes the latched limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != mbet_pkg::ST_IDLE |-> count_reg <= limit_reg)
        else $error("iteration count beyond limit");

    // squares are never negative when the bound is tested
    a_square_sign: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mbet_pkg::ST_CHECK |-> !tr_reg[FxW-1] && !ti_reg[FxW-1])
        else $error("negative square at escape test");

    // a finished pixel with a free output register shows up as a result
    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mbet_pkg::ST_DONE && done_free
        |=> out_valid_reg && state_reg == mbet_pkg::ST_IDLE)
        else $error("finished pixel not delivered");

    // pixels that stay inside are black
    a_inside_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.escaped
        |-> out_reg.red == '0 && out_reg.green == '0 && out_reg.blue == '0)
        else $error("inside pixel has color");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the escape-time pixel engine: pixel transactions go
// in under random flow control, every result transaction is checked field by
// field against an in-bench fixed-point orbit predictor
// ----------------------------------------------------------------------------

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // engine parameters, kept equal to the values the dut is built with
    localparam int FRAC_BITS    = 28;
    localparam int ESCAPE_BOUND = 4;
    localparam int COLUMN_LIMIT = 1024;
    localparam int ROW_LIMIT    = 1024;

    localparam int RANDOM_PIXELS   = 1600;
    localparam int SQUEEZE_AT      = 20;
    localparam int SQUEEZE_CYCLES  = 3000;
    localparam int WATCHDOG_CYCLES = 40000;
    localparam int SETTLE_CYCLES   = 64;

    typedef logic signed [mbet_pkg::FX_W-1:0] fx_t;

    // ------------------------------------------------------------------------
    // scoreboard: register copy, orbit predictor, queue of expected pixels
    // ------------------------------------------------------------------------
    class pixel_scoreboard;

        logic [31:0]                  x_origin;
        logic [31:0]                  y_origin;
        logic [mbet_pkg::STEP_W-1:0]  x_step;
        logic [mbet_pkg::STEP_W-1:0]  y_step;
        logic [mbet_pkg::COUNT_W-1:0] iteration_limit;
        logic [mbet_pkg::COLOR_W-1:0] palette_red;
        logic [mbet_pkg::COLOR_W-1:0] palette_green;
        logic [mbet_pkg::COLOR_W-1:0] palette_blue;
        mbet_pkg::result_t            expected_pixels[$];
        int unsigned                  failures;

        function new();
            x_origin        = mbet_pkg::RST_X_ORIGIN;
            y_origin        = mbet_pkg::RST_Y_ORIGIN;
            x_step          = mbet_pkg::RST_X_STEP;
            y_step          = mbet_pkg::RST_Y_STEP;
            iteration_limit = mbet_pkg::RST_ITER_LIMIT;
            palette_red     = mbet_pkg::RST_PALETTE_RED;
            palette_green   = mbet_pkg::RST_PALETTE_GREEN;
            palette_blue    = mbet_pkg::RST_PALETTE_BLUE;
            failures        = 0;
        endfunction

        function void set_register(logic [mbet_pkg::CFG_INDEX_W-1:0] index,
                                   logic [mbet_pkg::CFG_DATA_W-1:0] data);
            case (index)
                mbet_pkg::CFG_X_ORIGIN:      x_origin        = data;
                mbet_pkg::CFG_Y_ORIGIN:      y_origin        = data;
                mbet_pkg::CFG_X_STEP:        x_step          = data[mbet_pkg::STEP_W-1:0];
                mbet_pkg::CFG_Y_STEP:        y_step          = data[mbet_pkg::STEP_W-1:0];
                mbet_pkg::CFG_ITER_LIMIT:    iteration_limit = data[mbet_pkg::COUNT_W-1:0];
                mbet_pkg::CFG_PALETTE_RED:   palette_red     = data[mbet_pkg::COLOR_W-1:0];
                mbet_pkg::CFG_PALETTE_GREEN: palette_green   = data[mbet_pkg::COLOR_W-1:0];
                mbet_pkg::CFG_PALETTE_BLUE:  palette_blue    = data[mbet_pkg::COLOR_W-1:0];
                default: ;
            endcase
        endfunction

        // saturating 64-bit signed add
        function fx_t sat_sum(fx_t a, fx_t b);
            logic [mbet_pkg::FX_W:0] s;
            s = {a[mbet_pkg::FX_W-1], a} + {b[mbet_pkg::FX_W-1], b};
            if (s[mbet_pkg::FX_W] != s[mbet_pkg::FX_W-1])
                return s[mbet_pkg::FX_W] ? fx_t'(mbet_pkg::FX_MIN) : fx_t'(mbet_pkg::FX_MAX);
            return fx_t'(s[mbet_pkg::FX_W-1:0]);
        endfunction

        // sign-magnitude fixed-point product, truncated toward zero, saturated
        function fx_t fx_product(fx_t a, fx_t b);
            logic [mbet_pkg::FX_W-1:0]   ua;
            logic [mbet_pkg::FX_W-1:0]   ub;
            logic [mbet_pkg::FX_W-1:0]   mag;
            logic [mbet_pkg::FX_W-1:0]   lim;
            logic [2*mbet_pkg::FX_W-1:0] full;
            logic                        neg;
            ua   = a[mbet_pkg::FX_W-1] ? (64'd0 - a) : a;
            ub   = b[mbet_pkg::FX_W-1] ? (64'd0 - b) : b;
            neg  = a[mbet_pkg::FX_W-1] ^ b[mbet_pkg::FX_W-1];
            full = {64'd0, ua} * {64'd0, ub};
            lim  = neg ? mbet_pkg::FX_MIN : mbet_pkg::FX_MAX;
            if (full[2*mbet_pkg::FX_W-1:mbet_pkg::FX_W+FRAC_BITS] != 0)
                mag = lim;
            else
                mag = full[mbet_pkg::FX_W+FRAC_BITS-1:FRAC_BITS];
            if (mag > lim)
                mag = lim;
            return neg ? fx_t'(64'd0 - mag) : fx_t'(mag);
        endfunction

        function mbet_pkg::result_t escape_result(mbet_pkg::pixel_t p);
            logic [mbet_pkg::COORD_W-1:0] col;
            logic [mbet_pkg::COORD_W-1:0] row;
            fx_t                          cr;
            fx_t                          ci;
            fx_t                          zr;
            fx_t                          zi;
            fx_t                          tr;
            fx_t                          ti;
            fx_t                          zr_zi;
            fx_t                          bound;
            int unsigned                  count;
            int unsigned                  shade;
            mbet_pkg::result_t            r;
            col   = (p.column >= COLUMN_LIMIT) ? mbet_pkg::COORD_W'(COLUMN_LIMIT - 1)
                                               : p.column;
            row   = (p.row >= ROW_LIMIT) ? mbet_pkg::COORD_W'(ROW_LIMIT - 1) : p.row;
            cr    = {{32{x_origin[31]}}, x_origin} + {54'd0, col} * {33'd0, x_step};
            ci    = {{32{y_origin[31]}}, y_origin} - {54'd0, row} * {33'd0, y_step};
            bound = fx_t'(64'(ESCAPE_BOUND) << FRAC_BITS);
            zr    = '0;
            zi    = '0;
            tr    = '0;
            ti    = '0;
            count = 0;
            while (count < iteration_limit && sat_sum(tr, ti) <= bound)
            begin
                zr_zi = fx_product(zr, zi);
                zi    = sat_sum(sat_sum(zr_zi, zr_zi), ci);
                zr    = sat_sum(sat_sum(tr, -ti), cr);
                tr    = fx_product(zr, zr);
                ti    = fx_product(zi, zi);
                count++;
            end
            shade          = count + mbet_pkg::SHADE_OFFSET;
            r.pixel_column = p.column;
            r.pixel_row    = p.row;
            r.iterations   = count[mbet_pkg::COUNT_W-1:0];
            r.escaped      = (count != iteration_limit);
            r.red          = r.escaped ? mbet_pkg::COLOR_W'(palette_red * shade) : '0;
            r.green        = r.escaped ? mbet_pkg::COLOR_W'(palette_green * shade) : '0;
            r.blue         = r.escaped ? mbet_pkg::COLOR_W'(palette_blue * shade) : '0;
            return r;
        endfunction

        function void note_pixel(mbet_pkg::pixel_t p);
            expected_pixels.push_back(escape_result(p));
        endfunction

        function void field_mismatch(string field, int unsigned want, int unsigned seen);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
            failures++;
        endfunction

        function void check_pixel(mbet_pkg::result_t got);
            mbet_pkg::result_t want;
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                failures++;
                return;
            end
            want = expected_pixels.pop_front();
            if (got.pixel_column !== want.pixel_column)
                field_mismatch("pixel_column", want.pixel_column, got.pixel_column);
            if (got.pixel_row !== want.pixel_row)
                field_mismatch("pixel_row", want.pixel_row, got.pixel_row);
            if (got.iterations !== want.iterations)
                field_mismatch("iterations", want.iterations, got.iterations);
            if (got.escaped !== want.escaped)
                field_mismatch("escaped", want.escaped, got.escaped);
            if (got.red !== want.red)
                field_mismatch("red", want.red, got.red);
            if (got.green !== want.green)
                field_mismatch("green", want.green, got.green);
            if (got.blue !== want.blue)
                field_mismatch("blue", want.blue, got.blue);
        endfunction

        function int unsigned pending();
            return expected_pixels.size();
        endfunction

        function bit all_matched();
            if (expected_pixels.size() != 0)
            begin
                $display("%0t: %0d expected results never arrived", $time, expected_pixels.size());
                failures++;
            end
            return failures == 0;
        endfunction

    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels and the engine itself
    // ------------------------------------------------------------------------
    logic                             clk;
    logic                             rst_n;
    logic                             cfg_write;
    logic [mbet_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [mbet_pkg::CFG_DATA_W-1:0]  cfg_data;

    // steady: no idling on either side for the current phase
    bit steady;
    // squeeze: one long receiver hold-off while the sender keeps offering
    bit squeeze_request;
    bit squeeze_done;

    pixel_scoreboard board;

    mbet_stream_if #(.payload_t(mbet_pkg::pixel_t))  pixel_ch ();
    mbet_stream_if #(.payload_t(mbet_pkg::result_t)) result_ch ();

    mandelbrot_escape_time_pixel_top #(
        .FRAC_BITS    (FRAC_BITS),
        .ESCAPE_BOUND (ESCAPE_BOUND),
        .COLUMN_LIMIT (COLUMN_LIMIT),
        .ROW_LIMIT    (ROW_LIMIT)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel_ch),
        .result    (result_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // monitors: both channels sampled at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        // an accepted pixel transaction gets its prediction right away,
        // registers only change while the engine is idle
        if (rst_n && pixel_ch.valid && pixel_ch.ready)
            board.note_pixel(pixel_ch.payload);
        if (rst_n && result_ch.valid && result_ch.ready)
            board.check_pixel(result_ch.payload);
    end

    // watchdog: too many cycles with no transaction on either channel
    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_CYCLES)
        begin
            @(posedge clk);
            if (!rst_n || (pixel_ch.valid && pixel_ch.ready)
                       || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_CYCLES);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // flow control helpers
    // ------------------------------------------------------------------------

    // mostly back to back, some short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 20);
        return $urandom_range(30, 300);
    endfunction

    // result receiver: random hold-offs between transactions, plus the
    // one long squeeze that backs the engine up into its input
    initial
    begin
        int unsigned stall;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (squeeze_request && !squeeze_done)
            begin
                stall        = SQUEEZE_CYCLES;
                squeeze_done = 1'b1;
            end
            else
                stall = pick_gap();
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (result_ch.valid !== 1'b1);
        end
    end

    // offer one pixel and hold it until the engine takes it, then maybe
    // leave a gap before the next one
    task automatic offer_pixel(input logic [mbet_pkg::COORD_W-1:0] column,
                               input logic [mbet_pkg::COORD_W-1:0] row);
        mbet_pkg::pixel_t item;
        int unsigned      gap;
        item.column = column;
        item.row    = row;
        @(negedge clk);
        pixel_ch.valid   <= 1'b1;
        pixel_ch.payload <= item;
        do @(posedge clk); while (pixel_ch.ready !== 1'b1);
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            pixel_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // stop offering and wait until every predicted result has come back,
    // the engine is idle after that
    task automatic drain_results();
        @(negedge clk);
        pixel_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
    endtask

    task automatic write_register(input logic [mbet_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [mbet_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        board.set_register(index, data);
    endtask

    // full view and palette setup, every register each time
    task automatic load_view(input logic [31:0] x_origin, input logic [31:0] y_origin,
                             input logic [31:0] x_step, input logic [31:0] y_step,
                             input logic [31:0] limit, input logic [31:0] red,
                             input logic [31:0] green, input logic [31:0] blue);
        write_register(mbet_pkg::CFG_X_ORIGIN, x_origin);
        write_register(mbet_pkg::CFG_Y_ORIGIN, y_origin);
        write_register(mbet_pkg::CFG_X_STEP, x_step);
        write_register(mbet_pkg::CFG_Y_STEP, y_step);
        write_register(mbet_pkg::CFG_ITER_LIMIT, limit);
        write_register(mbet_pkg::CFG_PALETTE_RED, red);
        write_register(mbet_pkg::CFG_PALETTE_GREEN, green);
        write_register(mbet_pkg::CFG_PALETTE_BLUE, blue);
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned sent;
        int unsigned batch;
        int unsigned limit;
        int          xi;
        int          yi;
        logic [31:0] xo;
        logic [31:0] yo;
        logic [31:0] xs;
        logic [31:0] ys;

        board           = new();
        rst_n           = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        pixel_ch.valid   = 1'b0;
        pixel_ch.payload = '0;
        result_ch.ready  = 1'b0;
        steady          = 1'b0;
        squeeze_request = 1'b0;
        squeeze_done    = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset view: corners escape at once, the points near (-0.5, 0)
        // stay inside and run the full 255 iterations
        offer_pixel(10'd0, 10'd0);
        offer_pixel(10'd1023, 10'd1023);
        offer_pixel(10'd1023, 10'd0);
        offer_pixel(10'd0, 10'd1023);
        offer_pixel(10'd320, 10'd240);
        offer_pixel(10'd341, 10'd341);
        offer_pixel(10'd511, 10'd512);
        offer_pixel(10'd200, 10'd150);
        drain_results();

        // extreme corner of the plane, widest steps (top bit of the step
        // data must be dropped), limit of one: the bound is exceeded on the
        // last iteration, so nothing counts as escaped
        load_view(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'd1, 32'd255, 32'd255, 32'd255);
        offer_pixel(10'd0, 10'd0);
        offer_pixel(10'd1023, 10'd1023);
        offer_pixel(10'd1023, 10'd0);
        offer_pixel(10'd0, 10'd1023);
        drain_results();

        // zero iteration limit (upper data bits are dropped), zero steps
        load_view(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0,
                  32'h0001_0000, 32'd0, 32'd0, 32'd0);
        offer_pixel(10'd5, 10'd7);
        offer_pixel(10'd1023, 10'd1023);
        drain_results();

        // largest limit, but c sits far outside so every orbit leaves fast
        load_view(32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0,
                  32'd65535, 32'd255, 32'd0, 32'd128);
        offer_pixel(10'd0, 10'd0);
        offer_pixel(10'd1023, 10'd1023);
        offer_pixel(10'd682, 10'd341);
        drain_results();

        // random phases: mostly views around the set with short limits,
        // now and then a view anywhere on the plane that saturates
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                xo    = $urandom();
                yo    = $urandom();
                xs    = $urandom();
                ys    = $urandom();
                limit = $urandom_range(1, 12);
            end
            else
            begin
                // origin in [-2.5, 0.5] x [-1.5, 1.5], zoom picked at random
                xi    = -671088640 + int'($urandom_range(0, 805306368));
                yi    = -402653184 + int'($urandom_range(0, 805306368));
                xo    = xi;
                yo    = yi;
                xs    = $urandom_range(0, 1 << $urandom_range(10, 20));
                ys    = $urandom_range(0, 1 << $urandom_range(10, 20));
                limit = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 40)
                                                    : $urandom_range(2, 20);
            end
            load_view(xo, yo, xs, ys, limit, $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 255));
            steady = ($urandom_range(0, 3) == 0);
            batch  = $urandom_range(100, 160);
            repeat (batch)
            begin
                offer_pixel(mbet_pkg::COORD_W'($urandom_range(0, 1023)),
                            mbet_pkg::COORD_W'($urandom_range(0, 1023)));
                sent++;
                // mid-phase, so pixels keep coming while the receiver holds
                if (sent == SQUEEZE_AT)
                    squeeze_request = 1'b1;
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.all_matched())
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mbet_pkg.sv
rtl/mbet_stream_if.sv
rtl/mandelbrot_escape_time_pixel_top.sv
tb/tb_top.sv
